>>> hdl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants for the 3x3 fixed-point matrix inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

  // Default element format: signed Q16.16.
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Elements in one 3x3 matrix.
  localparam int N_ELEM = 9;

  // Flag positions in the result tuser field.
  localparam int USER_SINGULAR  = 0;
  localparam int USER_SATURATED = 1;
  localparam int USER_WIDTH     = 2;

endpackage

>>> hdl/matrix_inverse_3x3.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Inverse of a signed fixed-point 3x3 matrix by the adjugate, with
// truncating division, saturation and a singular flag.
// ----------------------------------------------------------------------------
//  channel   direction  transfer carries
//  s_axis    in         one matrix a11..a33
//  m_axis    out        inverse b11..b33 and flags singular, saturated
//
// One matrix per cycle is accepted and one result per cycle is delivered while m_tready stays high.
// The path runs through 5 front stages, the queue, DATA_WIDTH + 1 divider stages and
// the result register; the bit-per-stage dividers set the depth.
// Reset clears only the valid bits, queue pointers and fill count; no clearing pass.
// A stalled output holds the back part; the two-entry queue lets the front
// keep going until it fills, after which s_tready falls.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3
  import mi3_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int TDW       = ((N_ELEM * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDW-1:0]        s_tdata,   // a11, a12, a13, a21, .. a33, zero fill
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDW-1:0]        m_tdata,   // b11, b12, b13, b21, .. b33, zero fill
  output logic [USER_WIDTH-1:0] m_tuser    // singular, saturated
);

  localparam int DW = DATA_WIDTH;
  localparam int NW = 2 * DW + 2 * FRAC_BITS;
  localparam int QW = N_ELEM * NW + N_ELEM + 3 * DW + 1;

  logic                        f_valid;
  logic                        f_ready;
  logic [N_ELEM-1:0][NW-1:0]   f_num;
  logic [N_ELEM-1:0]           f_neg;
  logic [3*DW-1:0]             f_dmag;
  logic                        f_singular;

  logic                        q_valid;
  logic                        q_ready;
  logic [QW-1:0]               q_data;

  logic [N_ELEM-1:0][DW-1:0]   b_data;
  logic                        b_singular;
  logic                        b_saturated;

  // Cofactors, determinant and classification.
  mi3_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_data      (s_tdata[N_ELEM*DW-1:0]),
    .out_valid    (f_valid),
    .out_ready    (f_ready),
    .out_num      (f_num),
    .out_neg      (f_neg),
    .out_dmag     (f_dmag),
    .out_singular (f_singular)
  );

  // Decoupling queue.
  mi3_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_singular, f_dmag, f_neg, f_num}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // Division, saturation and result register.
  mi3_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (q_valid),
    .in_ready      (q_ready),
    .in_num        (q_data[N_ELEM*NW-1:0]),
    .in_neg        (q_data[N_ELEM*NW +: N_ELEM]),
    .in_dmag       (q_data[N_ELEM*NW+N_ELEM +: 3*DW]),
    .in_singular   (q_data[QW-1]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_data      (b_data),
    .out_singular  (b_singular),
    .out_saturated (b_saturated)
  );

  // Output packing.
  assign m_tdata                 = TDW'(b_data);
  assign m_tuser[USER_SINGULAR]  = b_singular;
  assign m_tuser[USER_SATURATED] = b_saturated;

endmodule

>>> hdl/mi3_front.sv
// ----------------------------------------------------------------------------
// mi3_front
// Front part: takes one matrix per transfer, forms the signed cofactors and
// the determinant, and classifies the item (singular, signs, magnitudes).
// ----------------------------------------------------------------------------
module mi3_front
  import mi3_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int NW        = 2 * DATA_WIDTH + 2 * FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [N_ELEM*DATA_WIDTH-1:0]         in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [N_ELEM-1:0][NW-1:0]            out_num,
  output logic [N_ELEM-1:0]                    out_neg,
  output logic [3*DATA_WIDTH-1:0]              out_dmag,
  output logic                                 out_singular
);

  localparam int DW  = DATA_WIDTH;
  localparam int MW  = 2 * DW + 1;
  localparam int PW  = 2 * DW + 1;
  localparam int DTW = 3 * DW + 1;

  logic adv;
  logic v1, v2, v3, v4, v5;

  logic signed [DW-1:0]   e1   [N_ELEM];
  logic signed [2*DW-1:0] p2a  [N_ELEM];
  logic signed [2*DW-1:0] p2b  [N_ELEM];
  logic signed [DW-1:0]   e2   [3];
  logic signed [MW-1:0]   cof3 [N_ELEM];
  logic signed [DW-1:0]   e3   [3];
  logic signed [PW-1:0]   plo4 [3];
  logic signed [PW-1:0]   phi4 [3];
  logic signed [MW-1:0]   cof4 [N_ELEM];
  logic signed [MW-1:0]   cof5 [N_ELEM];
  logic signed [DTW-1:0]  det5;
  logic signed [DTW-1:0]  det_sum;

  // The whole front moves unless its last stage holds an item the queue refuses.
  assign adv       = !v5 || out_ready;
  assign in_ready  = adv;
  assign out_valid = v5;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Stage 1 registers the elements.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < N_ELEM; k++) begin
        e1[k] <= in_data[k*DW +: DW];
      end
    end
  end

  // Stages 2 and 3 form the 2x2 minors and apply the checkerboard signs.
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int R0 = (i == 0) ? 1 : 0;
      localparam int R1 = (i == 2) ? 1 : 2;
      localparam int C0 = (j == 0) ? 1 : 0;
      localparam int C1 = (j == 2) ? 1 : 2;
      localparam int K  = i * 3 + j;
      localparam bit ODD = ((i + j) % 2) == 1;

      logic signed [MW-1:0] diff;

      assign diff = {p2a[K][2*DW-1], p2a[K]} - {p2b[K][2*DW-1], p2b[K]};

      always_ff @(posedge clk) begin
        if (adv) begin
          p2a[K]  <= e1[R0*3+C0] * e1[R1*3+C1];
          p2b[K]  <= e1[R1*3+C0] * e1[R0*3+C1];
          cof3[K] <= ODD ? -diff : diff;
        end
      end
    end
  end

  // Stage 4 splits each first-row term into two narrower products.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        e2[j]   <= e1[j];
        e3[j]   <= e2[j];
        plo4[j] <= e3[j] * $signed({1'b0, cof3[j][DW-1:0]});
        phi4[j] <= e3[j] * $signed(cof3[j][MW-1:DW]);
      end
      cof4 <= cof3;
      cof5 <= cof4;
      det5 <= det_sum;
    end
  end

  // Stage 5 sums the partial products into the determinant.
  always_comb begin
    det_sum = '0;
    for (int j = 0; j < 3; j++) begin
      det_sum = det_sum + $signed({phi4[j], {DW{1'b0}}})
                        + $signed({{DW{plo4[j][PW-1]}}, plo4[j]});
    end
  end

  // Classification: singular flag, divisor magnitude, transposed numerators.
  logic                 dneg;
  logic [DTW-1:0]       dabs;

  assign out_singular = (det5 == '0);
  assign dneg         = det5[DTW-1];
  assign dabs         = dneg ? DTW'(-det5) : DTW'(det5);
  assign out_dmag     = dabs[3*DW-1:0];

  for (genvar i = 0; i < 3; i++) begin : g_adj_row
    for (genvar j = 0; j < 3; j++) begin : g_adj_col
      logic          cneg;
      logic [MW-1:0] cabs;

      assign cneg = cof5[j*3+i][MW-1];
      assign cabs = cneg ? MW'(-cof5[j*3+i]) : MW'(cof5[j*3+i]);
      assign out_num[i*3+j] = NW'(cabs[2*DW-1:0]) << (2 * FRAC_BITS);
      assign out_neg[i*3+j] = cneg != dneg;
    end
  end

endmodule

>>> hdl/mi3_queue.sv
// ----------------------------------------------------------------------------
// mi3_queue
// Two-entry queue between the front and the back of the inverse.
// ----------------------------------------------------------------------------
module mi3_queue
  import mi3_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // The count stays within the depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");

  // Occupancy rises by one after a push without a pop.
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1)
    else $error("queue count did not follow a push");

  // With both pointers equal the queue is either empty or full.
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    wr_ptr == rd_ptr |-> count == 2'd0 || count == 2'd2)
    else $error("queue pointers disagree with count");

endmodule

>>> hdl/mi3_back.sv
// ----------------------------------------------------------------------------
// mi3_back
// Back part: nine pipelined restoring dividers, one quotient bit per stage,
// then saturation and the result register.
// ----------------------------------------------------------------------------
module mi3_back
  import mi3_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int NW        = 2 * DATA_WIDTH + 2 * FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [N_ELEM-1:0][NW-1:0]           in_num,
  input  logic [N_ELEM-1:0]                   in_neg,
  input  logic [3*DATA_WIDTH-1:0]             in_dmag,
  input  logic                                in_singular,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [N_ELEM-1:0][DATA_WIDTH-1:0]   out_data,
  output logic                                out_singular,
  output logic                                out_saturated
);

  localparam int DW = DATA_WIDTH;
  localparam int CW = (NW > 4 * DW) ? NW : 4 * DW;

  logic adv;

  logic              v_st    [0:DW];
  logic [CW-1:0]     rem_st  [0:DW][N_ELEM];
  logic [DW-1:0]     q_st    [0:DW][N_ELEM];
  logic [N_ELEM-1:0] ovf_st  [0:DW];
  logic [N_ELEM-1:0] neg_st  [0:DW];
  logic [3*DW-1:0]   dmag_st [0:DW];
  logic              sing_st [0:DW];

  logic [CW-1:0]     sub_c   [1:DW][N_ELEM];
  logic              ge_c    [1:DW][N_ELEM];

  logic [N_ELEM-1:0][DW-1:0] res_c;
  logic [N_ELEM-1:0]         sat_c;
  logic [N_ELEM-1:0]         ext_c;
  logic [DW-1:0]             lim;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign lim      = DW'(1) << (DW - 1);

  // Valid bits of the divider stages and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DW; s++) begin
        v_st[s] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (adv) begin
      v_st[0] <= in_valid;
      for (int s = 1; s <= DW; s++) begin
        v_st[s] <= v_st[s-1];
      end
      out_valid <= v_st[DW];
    end
  end

  // Trial subtraction of the shifted divisor in every stage and lane.
  always_comb begin
    for (int s = 1; s <= DW; s++) begin
      for (int l = 0; l < N_ELEM; l++) begin
        sub_c[s][l] = CW'(dmag_st[s-1]) << (DW - s);
        ge_c[s][l]  = rem_st[s-1][l] >= sub_c[s][l];
      end
    end
  end

  // Load checks for a quotient too wide for the result, then one bit a stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < N_ELEM; l++) begin
        rem_st[0][l]    <= CW'(in_num[l]);
        q_st[0][l]      <= '0;
        ovf_st[0][l]    <= CW'(in_num[l]) >= (CW'(in_dmag) << DW);
      end
      neg_st[0]  <= in_neg;
      dmag_st[0] <= in_dmag;
      sing_st[0] <= in_singular;
      for (int s = 1; s <= DW; s++) begin
        for (int l = 0; l < N_ELEM; l++) begin
          rem_st[s][l] <= ge_c[s][l] ? rem_st[s-1][l] - sub_c[s][l] : rem_st[s-1][l];
          q_st[s][l]   <= q_st[s-1][l] | (ge_c[s][l] ? DW'(1) << (DW - s) : '0);
        end
        ovf_st[s]  <= ovf_st[s-1];
        neg_st[s]  <= neg_st[s-1];
        dmag_st[s] <= dmag_st[s-1];
        sing_st[s] <= sing_st[s-1];
      end
    end
  end

  // Sign, saturation and the singular case.
  always_comb begin
    for (int l = 0; l < N_ELEM; l++) begin
      sat_c[l] = 1'b0;
      res_c[l] = '0;
      if (!sing_st[DW]) begin
        if (ovf_st[DW][l] ||
            (neg_st[DW][l] ? (q_st[DW][l] > lim) : (q_st[DW][l] >= lim))) begin
          sat_c[l] = 1'b1;
          res_c[l] = neg_st[DW][l] ? lim : lim - DW'(1);
        end else begin
          res_c[l] = neg_st[DW][l] ? DW'(-q_st[DW][l]) : q_st[DW][l];
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data      <= res_c;
      out_singular  <= sing_st[DW];
      out_saturated <= |sat_c;
    end
  end

  // Marks a result element that sits at either end of the range.
  always_comb begin
    for (int l = 0; l < N_ELEM; l++) begin
      ext_c[l] = (out_data[l] == lim) || (out_data[l] == lim - DW'(1));
    end
  end

  // A singular result is all zeros and never clipped.
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_singular |-> out_data == '0 && !out_saturated)
    else $error("singular result not cleared");

  // A clipped result has at least one element at a range limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_saturated |-> ext_c != '0)
    else $error("saturation flag without a limit value");

  // An item entering the divider moves on when the pipe advances.
  a_stage_move: assert property (@(posedge clk) disable iff (rst)
    v_st[0] && adv |=> v_st[1])
    else $error("divider stage lost an item");

endmodule
